// ===== hw/rtl/sal_pkg.sv =====
// Shared types and constants for the shelf atlas allocator.
// No dependencies; imported by sal_ifs, sal_ctrl and the top level.
package sal_pkg;

    localparam int GLYPH_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int PAGE_IDX_W  = 4;
    localparam int COORD_W     = 10;
    localparam int PAGE_EXT_W  = 8;

    localparam int DEF_PAGE_SIZE = 1024;
    localparam int DEF_MAX_PAGES = 16;
    localparam int DEF_PADDING   = 1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_PLACED = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

    typedef struct packed {
        status_t                 status;
        logic [PAGE_IDX_W-1:0]   page_index;
        logic                    page_opened;
        logic [COORD_W-1:0]      cell_x;
        logic [COORD_W-1:0]      cell_y;
    } result_t;

endpackage

// ===== hw/rtl/sal_ifs.sv =====
// Channel interfaces: glyph size requests in, cell placements out.
// Depends on sal_pkg.
interface sal_glyph_if
    import sal_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [GLYPH_W-1:0] glyph_width;
    logic [GLYPH_W-1:0] glyph_height;

    modport source (output valid, output glyph_width, output glyph_height, input ready);
    modport sink   (input valid, input glyph_width, input glyph_height, output ready);
endinterface

interface sal_cell_if
    import sal_pkg::*;
();
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [PAGE_IDX_W-1:0] page_index;
    logic                  page_opened;
    logic [COORD_W-1:0]    cell_x;
    logic [COORD_W-1:0]    cell_y;

    modport source (output valid, output status, output page_index, output page_opened,
                    output cell_x, output cell_y, input ready);
    modport sink   (input valid, input status, input page_index, input page_opened,
                    input cell_x, input cell_y, output ready);
endinterface

// ===== hw/rtl/sal_shelf_mem.sv =====
// Per-page shelf state memory: one write port, one read port, registered read.
// No dependencies.
module sal_shelf_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 33
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sal_fit.sv =====
// Fit check and updated shelf for one page entry against one padded cell.
// No dependencies.
module sal_fit #(
    parameter int CW        = 11,
    parameter int AW        = 13,
    parameter int PAGE_SIZE = 1024
) (
    input  logic [CW-1:0] cur,
    input  logic [CW-1:0] top,
    input  logic [CW-1:0] hgt,
    input  logic [CW-1:0] cw,
    input  logic [CW-1:0] ch,
    output logic          fits,
    output logic [CW-1:0] x,
    output logic [CW-1:0] y,
    output logic [CW-1:0] new_cur,
    output logic [CW-1:0] new_top,
    output logic [CW-1:0] new_hgt
);

    logic [AW-1:0] sum_x;
    logic [AW-1:0] base;
    logic [AW-1:0] nx;
    logic [AW-1:0] bottom;
    logic          new_shelf;

    always_comb
    begin
        sum_x     = AW'(cur) + AW'(cw);
        base      = AW'(top) + AW'(hgt);
        new_shelf = (sum_x > AW'(PAGE_SIZE)) || (hgt < ch);
        nx        = new_shelf ? AW'(cw) : sum_x;
        bottom    = new_shelf ? base + AW'(ch) : base;
        fits      = (nx <= AW'(PAGE_SIZE)) && (bottom <= AW'(PAGE_SIZE));
        x         = new_shelf ? '0 : cur;
        y         = new_shelf ? CW'(base) : top;
        new_cur   = CW'(nx);
        new_top   = y;
        new_hgt   = new_shelf ? ch : hgt;
    end

endmodule

// ===== hw/rtl/sal_ctrl.sv =====
// Request sequencer: classifies a glyph, scans pages newest first through the
// shelf memory, opens pages and writes back the updated shelf. Depends on sal_pkg.
module sal_ctrl
    import sal_pkg::*;
#(
    parameter int PAGE_SIZE = DEF_PAGE_SIZE,
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int PADDING   = DEF_PADDING,
    parameter int CW        = $clog2(PAGE_SIZE) + 1,
    parameter int IW        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    sal_glyph_if.sink     req,
    output logic          res_valid,
    output result_t       res,
    input  logic          res_take,
    output logic          rd_en,
    output logic [IW-1:0] rd_addr,
    input  logic [3*CW-1:0] rd_data,
    output logic          wr_en,
    output logic [IW-1:0] wr_addr,
    output logic [3*CW-1:0] wr_data
);

    localparam int AW = (CW + 2 > 12) ? CW + 2 : 12;
    localparam int PW = $clog2(MAX_PAGES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OPEN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cw_reg, cw_next;
    logic [CW-1:0] ch_reg, ch_next;
    logic [IW-1:0] pend_reg, pend_next;
    logic [PW-1:0] open_cnt_reg, open_cnt_next;
    result_t       res_reg, res_next;

    logic [AW-1:0] cw_full;
    logic [AW-1:0] ch_full;
    logic          is_empty;
    logic          too_big;

    logic          fits;
    logic [CW-1:0] fx, fy, f_cur, f_top, f_hgt;
    logic [AW-1:0] fx_ext, fy_ext;
    logic [PAGE_EXT_W-1:0] pend_ext, open_ext;

    sal_fit #(
        .CW        (CW),
        .AW        (AW),
        .PAGE_SIZE (PAGE_SIZE)
    ) u_fit (
        .cur     (rd_data[3*CW-1:2*CW]),
        .top     (rd_data[2*CW-1:CW]),
        .hgt     (rd_data[CW-1:0]),
        .cw      (cw_reg),
        .ch      (ch_reg),
        .fits    (fits),
        .x       (fx),
        .y       (fy),
        .new_cur (f_cur),
        .new_top (f_top),
        .new_hgt (f_hgt)
    );

    assign cw_full  = AW'(req.glyph_width) + AW'(2 * PADDING);
    assign ch_full  = AW'(req.glyph_height) + AW'(2 * PADDING);
    assign is_empty = (req.glyph_width == '0) || (req.glyph_height == '0);
    assign too_big  = (cw_full > AW'(PAGE_SIZE)) || (ch_full > AW'(PAGE_SIZE));
    assign fx_ext   = AW'(fx);
    assign fy_ext   = AW'(fy);
    assign pend_ext = PAGE_EXT_W'(pend_reg);
    assign open_ext = PAGE_EXT_W'(open_cnt_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cw_next       = cw_reg;
        ch_next       = ch_reg;
        pend_next     = pend_reg;
        open_cnt_next = open_cnt_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cw_next  = CW'(cw_full);
                    ch_next  = CW'(ch_full);
                    res_next = '0;
                    if (is_empty)
                    begin
                        res_next.status = ST_EMPTY;
                        state_next      = S_DONE;
                    end
                    else if (too_big)
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else if (open_cnt_reg == '0)
                    begin
                        state_next = S_OPEN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = IW'(open_cnt_reg - PW'(1));
                        pend_next  = IW'(open_cnt_reg - PW'(1));
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // speculative read of the next older page
                rd_en   = (pend_reg != '0);
                rd_addr = pend_reg - IW'(1);
                if (fits)
                begin
                    wr_en                = 1'b1;
                    wr_addr              = pend_reg;
                    wr_data              = {f_cur, f_top, f_hgt};
                    res_next.status      = ST_PLACED;
                    res_next.page_index  = pend_ext[PAGE_IDX_W-1:0];
                    res_next.page_opened = 1'b0;
                    res_next.cell_x      = fx_ext[COORD_W-1:0];
                    res_next.cell_y      = fy_ext[COORD_W-1:0];
                    state_next           = S_DONE;
                end
                else if (pend_reg == '0)
                begin
                    state_next = S_OPEN;
                end
                else
                begin
                    pend_next = pend_reg - IW'(1);
                end
            end
            S_OPEN:
            begin
                res_next = '0;
                if (open_cnt_reg >= PW'(MAX_PAGES))
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    wr_en                = 1'b1;
                    wr_addr              = IW'(open_cnt_reg);
                    wr_data              = {cw_reg, {CW{1'b0}}, ch_reg};
                    res_next.status      = ST_PLACED;
                    res_next.page_index  = open_ext[PAGE_IDX_W-1:0];
                    res_next.page_opened = 1'b1;
                    open_cnt_next        = open_cnt_reg + PW'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            open_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            open_cnt_reg <= open_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg   <= cw_next;
        ch_reg   <= ch_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

endmodule

// ===== hw/rtl/shelf_atlas_allocator_core.sv =====
// Top level of the shelf atlas allocator: sequencer, shelf memory, output stage.
// Depends on sal_pkg, sal_ifs, sal_shelf_mem, sal_ctrl, sal_fit.
//
//  port  dir  transaction
//  ----  ---  ---------------------------------------------------------------
//  req   in   glyph_width, glyph_height
//  rsp   out  status, page_index, page_opened, cell_x, cell_y
//
// One request at a time. The accept cycle reads the newest page, then one page
// per cycle is checked from the newest down until one fits; if none fits, or no
// page is open, the open step opens a page or reports full. Empty or oversize
// glyphs skip the scan and go straight to the done state.
// Reset clears state, page count, rsp valid; entries are written as pages open.
// The output register lets a new request be accepted while rsp is stalled.
module shelf_atlas_allocator_core
    import sal_pkg::*;
#(
    parameter int PAGE_SIZE = DEF_PAGE_SIZE,
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int PADDING   = DEF_PADDING
) (
    input  logic       clk,
    input  logic       rst_n,
    sal_glyph_if.sink  req,
    sal_cell_if.source rsp
);

    localparam int CW = $clog2(PAGE_SIZE) + 1;
    localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    logic            res_valid;
    result_t         res;
    logic            res_take;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic [3*CW-1:0] rd_data;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [3*CW-1:0] wr_data;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    sal_ctrl #(
        .PAGE_SIZE (PAGE_SIZE),
        .MAX_PAGES (MAX_PAGES),
        .PADDING   (PADDING),
        .CW        (CW),
        .IW        (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    sal_shelf_mem #(
        .DEPTH  (MAX_PAGES),
        .ADDR_W (IW),
        .DATA_W (3 * CW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.page_index  = out_res_reg.page_index;
    assign rsp.page_opened = out_res_reg.page_opened;
    assign rsp.cell_x      = out_res_reg.cell_x;
    assign rsp.cell_y      = out_res_reg.cell_y;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ST_PLACED || rsp.status == ST_EMPTY
                       || rsp.status == ST_FULL))
        else $error("undefined status code");

    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_PLACED |-> rsp.page_index == '0
            && !rsp.page_opened && rsp.cell_x == '0 && rsp.cell_y == '0)
        else $error("unplaced transaction carries nonzero fields");

    a_new_page_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.page_opened |-> rsp.status == ST_PLACED
            && rsp.cell_x == '0 && rsp.cell_y == '0)
        else $error("new page placement not at origin");

    a_mem_ports_apart: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && rd_en |-> wr_addr != rd_addr)
        else $error("shelf memory read and write collide");

endmodule
